>>> hdl/diffusion_stencil_update_assert.svh
// ----------------------------------------------------------------------------
// Diffusion stencil update assertion macros
// Implication and next-cycle implication checks, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef DIFFUSION_STENCIL_UPDATE_ASSERT_SVH
`define DIFFUSION_STENCIL_UPDATE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DSU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dsu assertion failed");
`define DSU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dsu assertion failed");
`else
`define DSU_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DSU_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/dsu_pkg.sv
// ----------------------------------------------------------------------------
// dsu_pkg
// Widths, limits and shared types of the diffusion stencil update pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package dsu_pkg;

	localparam int PIX_W      = 32;
	localparam int FRAC_W     = 16;
	localparam int DIFF_W     = PIX_W + 1;
	localparam int PROD_W     = PIX_W + DIFF_W;
	localparam int TERM_W     = 48;
	localparam int SUM_W      = TERM_W + 2;
	localparam int SCALE_W    = 17;
	localparam int SPLIT_W    = 24;
	localparam int PPH_W      = SUM_W - SPLIT_W + SCALE_W + 1;
	localparam int PPL_W      = SPLIT_W + SCALE_W;
	localparam int TOT_W      = PPH_W + SPLIT_W;
	localparam int UPD_W      = TOT_W - FRAC_W;
	localparam int RES_W      = UPD_W + 1;
	localparam int DIV_NUM_W  = PIX_W + FRAC_W;
	localparam int DIV_DEN_W  = PIX_W - 1;
	localparam int DIV_STEP   = 4;
	localparam int DIV_STAGES = DIV_NUM_W / DIV_STEP;
	localparam int DIV_LAT    = DIV_STAGES + 2;

	localparam logic [SCALE_W-1:0] SCALE_RST = 17'd8192;
	localparam logic [PIX_W-1:0]   PIX_MAX   = 32'h7FFF_FFFF;
	localparam logic [PIX_W-1:0]   PIX_MIN   = 32'h8000_0000;

	typedef logic [PIX_W-1:0] pix_word_t;

	typedef struct packed {
		pix_word_t ctr;
		pix_word_t nth;
		pix_word_t sth;
		pix_word_t wst;
		pix_word_t est;
	} pix_set_t;

	typedef struct packed {
		logic adv;
		logic vld;
	} dsu_ctl_t;

endpackage

`default_nettype wire

>>> hdl/dsu_div.sv
// ----------------------------------------------------------------------------
// dsu_div
// Pipelined coefficient decoder: value*2^16 / tag for a positive tag, four
// quotient bits a stage, saturated to 32 bits; the value itself otherwise.
// ----------------------------------------------------------------------------
`default_nettype none

module dsu_div import dsu_pkg::*; (
	input  logic      clk,
	input  logic      adv,
	input  pix_word_t val,
	input  pix_word_t tag,
	output pix_word_t coef
);

	localparam logic [DIV_NUM_W-1:0] QPOS_LIM = {{(DIV_NUM_W-PIX_W){1'b0}}, PIX_MAX};
	localparam logic [DIV_NUM_W-1:0] QNEG_LIM = {{(DIV_NUM_W-PIX_W){1'b0}}, PIX_MIN};

	logic [DIV_DEN_W-1:0] rem_s [0:DIV_STAGES];
	logic [DIV_NUM_W-1:0] num_s [0:DIV_STAGES];
	logic [DIV_DEN_W-1:0] den_s [0:DIV_STAGES];
	logic                 neg_s [0:DIV_STAGES];
	logic                 byp_s [0:DIV_STAGES];
	pix_word_t            val_s [0:DIV_STAGES];
	pix_word_t            coef_sn;

	pix_word_t mag;
	logic      byp;
	pix_word_t coef_nx;
	logic [DIV_NUM_W-1:0] quo;

	assign mag = val[PIX_W-1] ? (~val + 1'b1) : val;
	assign byp = tag[PIX_W-1] || (tag == '0);

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0] <= '0;
			num_s[0] <= {mag, {FRAC_W{1'b0}}};
			den_s[0] <= tag[DIV_DEN_W-1:0];
			neg_s[0] <= val[PIX_W-1];
			byp_s[0] <= byp;
			val_s[0] <= val;
		end
	end

	for (genvar g = 1; g <= DIV_STAGES; g++) begin : g_stage
		logic [DIV_DEN_W-1:0] rem_nx;
		logic [DIV_NUM_W-1:0] num_nx;

		always_comb begin : iter
			logic [DIV_DEN_W:0]   t;
			logic [DIV_DEN_W-1:0] r;
			logic [DIV_NUM_W-1:0] n;
			logic                 qb;
			r  = rem_s[g-1];
			n  = num_s[g-1];
			t  = '0;
			qb = 1'b0;
			for (int i = 0; i < DIV_STEP; i++) begin
				t  = {r, n[DIV_NUM_W-1]};
				qb = (t >= {1'b0, den_s[g-1]});
				if (qb) begin
					t = t - {1'b0, den_s[g-1]};
				end
				r = t[DIV_DEN_W-1:0];
				n = {n[DIV_NUM_W-2:0], qb};
			end
			rem_nx = r;
			num_nx = n;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[g] <= rem_nx;
				num_s[g] <= num_nx;
				den_s[g] <= den_s[g-1];
				neg_s[g] <= neg_s[g-1];
				byp_s[g] <= byp_s[g-1];
				val_s[g] <= val_s[g-1];
			end
		end
	end

	assign quo = num_s[DIV_STAGES];

	always_comb begin
		if (byp_s[DIV_STAGES]) begin
			coef_nx = val_s[DIV_STAGES];
		end else if (neg_s[DIV_STAGES]) begin
			coef_nx = (quo > QNEG_LIM) ? PIX_MIN : (~quo[PIX_W-1:0] + 1'b1);
		end else begin
			coef_nx = (quo > QPOS_LIM) ? PIX_MAX : quo[PIX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			coef_sn <= coef_nx;
		end
	end

	assign coef = coef_sn;

endmodule

`default_nettype wire

>>> hdl/dsu_mac.sv
// ----------------------------------------------------------------------------
// dsu_mac
// Six-stage datapath: neighbour differences, coefficient products, sum,
// split scale multiply, scale shift, add to centre and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module dsu_mac import dsu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  dsu_ctl_t           ctl,
	input  pix_set_t           pix,
	input  pix_word_t          kc,
	input  pix_word_t          ks,
	input  pix_word_t          ke,
	input  logic [SCALE_W-1:0] scale,
	output pix_word_t          res,
	output logic               res_vld
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	logic signed [PIX_W-1:0]  kc_s1, ks_s1, ke_s1;
	logic signed [DIFF_W-1:0] dn_s1, dw_s1, ds_s1, de_s1;
	pix_word_t                c_s1, c_s2, c_s3, c_s4, c_s5;
	logic signed [TERM_W-1:0] tn_s2, tw_s2, ts_s2, te_s2;
	logic signed [SUM_W-1:0]  sum_s3;
	logic signed [PPH_W-1:0]  pph_s4;
	logic [PPL_W-1:0]         ppl_s4;
	logic signed [UPD_W-1:0]  upd_s5;
	pix_word_t                res_s6;

	logic signed [DIFF_W-1:0] c_ext;
	logic signed [PROD_W-1:0] pn, pw, ps, pe;
	logic signed [SUM_W-1:0]  sum_nx;
	logic signed [PPH_W-1:0]  pph_nx;
	logic [PPL_W-1:0]         ppl_nx;
	logic signed [TOT_W-1:0]  tot_nx;
	logic signed [RES_W-1:0]  r_nx;
	pix_word_t                res_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (ctl.adv) begin
			vld_s1 <= ctl.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	assign c_ext = $signed({pix.ctr[PIX_W-1], pix.ctr});

	assign pn = kc_s1 * dn_s1;
	assign pw = kc_s1 * dw_s1;
	assign ps = ks_s1 * ds_s1;
	assign pe = ke_s1 * de_s1;

	assign sum_nx = $signed({{(SUM_W-TERM_W){tn_s2[TERM_W-1]}}, tn_s2})
		+ $signed({{(SUM_W-TERM_W){tw_s2[TERM_W-1]}}, tw_s2})
		+ $signed({{(SUM_W-TERM_W){ts_s2[TERM_W-1]}}, ts_s2})
		+ $signed({{(SUM_W-TERM_W){te_s2[TERM_W-1]}}, te_s2});

	assign pph_nx = $signed(sum_s3[SUM_W-1:SPLIT_W]) * $signed({1'b0, scale});
	assign ppl_nx = sum_s3[SPLIT_W-1:0] * scale;

	assign tot_nx = $signed({pph_s4, {SPLIT_W{1'b0}}})
		+ $signed({{(TOT_W-PPL_W){1'b0}}, ppl_s4});

	assign r_nx = $signed({{(RES_W-PIX_W){c_s5[PIX_W-1]}}, c_s5})
		+ $signed({upd_s5[UPD_W-1], upd_s5});

	always_comb begin
		if (r_nx[RES_W-1] && !(&r_nx[RES_W-2:PIX_W-1])) begin
			res_nx = PIX_MIN;
		end else if (!r_nx[RES_W-1] && (|r_nx[RES_W-2:PIX_W-1])) begin
			res_nx = PIX_MAX;
		end else begin
			res_nx = r_nx[PIX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			kc_s1  <= $signed(kc);
			ks_s1  <= $signed(ks);
			ke_s1  <= $signed(ke);
			dn_s1  <= $signed({pix.nth[PIX_W-1], pix.nth}) - c_ext;
			dw_s1  <= $signed({pix.wst[PIX_W-1], pix.wst}) - c_ext;
			ds_s1  <= $signed({pix.sth[PIX_W-1], pix.sth}) - c_ext;
			de_s1  <= $signed({pix.est[PIX_W-1], pix.est}) - c_ext;
			c_s1   <= pix.ctr;
			tn_s2  <= pn[TERM_W+FRAC_W-1:FRAC_W];
			tw_s2  <= pw[TERM_W+FRAC_W-1:FRAC_W];
			ts_s2  <= ps[TERM_W+FRAC_W-1:FRAC_W];
			te_s2  <= pe[TERM_W+FRAC_W-1:FRAC_W];
			c_s2   <= c_s1;
			sum_s3 <= sum_nx;
			c_s3   <= c_s2;
			pph_s4 <= pph_nx;
			ppl_s4 <= ppl_nx;
			c_s4   <= c_s3;
			upd_s5 <= tot_nx[TOT_W-1:FRAC_W];
			c_s5   <= c_s4;
			res_s6 <= res_nx;
		end
	end

	assign res     = res_s6;
	assign res_vld = vld_s6;

endmodule

`default_nettype wire

>>> hdl/dsu_obuf.sv
// ----------------------------------------------------------------------------
// dsu_obuf
// Two-word output buffer; holds finished words while the sink stalls and
// tells the pipeline whether it may advance.
// ----------------------------------------------------------------------------
`default_nettype none

`include "diffusion_stencil_update_assert.svh"

module dsu_obuf import dsu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  pix_word_t din,
	output logic      room,
	output pix_word_t next_pix,
	output logic      next_valid,
	input  logic      next_stall
);

	localparam logic [1:0] CNT_FULL = 2'd2;

	logic [1:0] cnt_q;
	pix_word_t  ent0_q, ent1_q;
	logic       pop;

	assign pop        = (cnt_q != 2'd0) && !next_stall;
	assign room       = (cnt_q != CNT_FULL);
	assign next_valid = (cnt_q != 2'd0);
	assign next_pix   = ent0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !pop) begin
			if (cnt_q == 2'd0) begin
				ent0_q <= din;
			end else begin
				ent1_q <= din;
			end
		end else if (pop && !push) begin
			ent0_q <= ent1_q;
		end else if (pop && push) begin
			if (cnt_q == 2'd1) begin
				ent0_q <= din;
			end else begin
				ent0_q <= ent1_q;
				ent1_q <= din;
			end
		end
	end

	`DSU_ASSERT_IMP(a_no_overrun, clk, arst_n, push, cnt_q != CNT_FULL)
	`DSU_ASSERT_NXT(a_fill_step, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + 2'd1)
	`DSU_ASSERT_NXT(a_drain_step, clk, arst_n, pop && !push, cnt_q == $past(cnt_q) - 2'd1)

endmodule

`default_nettype wire

>>> hdl/diffusion_stencil_update.sv
// ----------------------------------------------------------------------------
// diffusion_stencil_update
// Path: an accepted pixel word passes 14 coefficient divider stages,
//   6 datapath stages and 1 output buffer on its way to next_pix.
// Throughput: one pixel word per cycle when not stalled; the divider retires
//   4 quotient bits in each of its 12 stages, each taking a word per cycle.
// A two-word output buffer takes results while next_stall is high; pix_stall
//   rises only when that buffer is full.
// Reset: clears all valid bits and the buffer; scale_q returns to 8192.
// ----------------------------------------------------------------------------
`default_nettype none

module diffusion_stencil_update import dsu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pix_valid,
	output logic               pix_stall,
	input  logic signed [31:0] center_pix,
	input  logic signed [31:0] north_pix,
	input  logic signed [31:0] south_pix,
	input  logic signed [31:0] west_pix,
	input  logic signed [31:0] east_pix,
	input  logic signed [31:0] center_coef_val,
	input  logic signed [31:0] center_coef_tag,
	input  logic signed [31:0] south_coef_val,
	input  logic signed [31:0] south_coef_tag,
	input  logic signed [31:0] east_coef_val,
	input  logic signed [31:0] east_coef_tag,
	output logic               next_valid,
	input  logic               next_stall,
	output logic signed [31:0] next_pix,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [16:0]        diff_scale
);

	logic [SCALE_W-1:0] scale_q;
	logic               vld_s [0:DIV_LAT-1];
	pix_set_t           pix_s [0:DIV_LAT-1];

	logic      adv;
	pix_word_t kc, ks, ke;
	pix_word_t res;
	logic      res_vld;
	pix_word_t out_word;
	dsu_ctl_t  mac_ctl;

	assign cfg_ready = 1'b1;
	assign pix_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			scale_q <= diff_scale;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_LAT; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[0] <= pix_valid;
			for (int k = 1; k < DIV_LAT; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s[0] <= '{ctr: center_pix, nth: north_pix, sth: south_pix,
				wst: west_pix, est: east_pix};
			for (int k = 1; k < DIV_LAT; k++) begin
				pix_s[k] <= pix_s[k-1];
			end
		end
	end

	dsu_div u_div_c (
		.clk  (clk),
		.adv  (adv),
		.val  (center_coef_val),
		.tag  (center_coef_tag),
		.coef (kc)
	);

	dsu_div u_div_s (
		.clk  (clk),
		.adv  (adv),
		.val  (south_coef_val),
		.tag  (south_coef_tag),
		.coef (ks)
	);

	dsu_div u_div_e (
		.clk  (clk),
		.adv  (adv),
		.val  (east_coef_val),
		.tag  (east_coef_tag),
		.coef (ke)
	);

	assign mac_ctl = '{adv: adv, vld: vld_s[DIV_LAT-1]};

	dsu_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mac_ctl),
		.pix     (pix_s[DIV_LAT-1]),
		.kc      (kc),
		.ks      (ks),
		.ke      (ke),
		.scale   (scale_q),
		.res     (res),
		.res_vld (res_vld)
	);

	dsu_obuf u_obuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (adv && res_vld),
		.din        (res),
		.room       (adv),
		.next_pix   (out_word),
		.next_valid (next_valid),
		.next_stall (next_stall)
	);

	assign next_pix = $signed(out_word);

endmodule

`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// Diffusion stencil update testbench
// Sends pixel words with neighbours and value/tag coefficients into
// diffusion_stencil_update and compares every next_pix with an independent
// fixed-point prediction. The input side sends in bursts with gaps, and the
// output side stalls in changing patterns, once for a long hold-off.
// diff_scale is rewritten between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb;
	import dsu_pkg::*;

	localparam int DRAIN_CYC    = 32;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYC     = 300;
	localparam pix_word_t ONE_Q = 32'h0001_0000;

	typedef struct packed {
		pix_word_t ctr, nth, sth, wst, est;
		pix_word_t kc_val, kc_tag, ks_val, ks_tag, ke_val, ke_tag;
	} stencil_t;

	typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PATTERN} stall_mode_t;

	class next_pix_tracker;
		logic [SCALE_W-1:0] scale;
		pix_word_t want_next[$];
		int bad_cnt;
		int seen_cnt;

		function new();
			scale = SCALE_RST;
			bad_cnt = 0;
			seen_cnt = 0;
		endfunction

		function logic signed [95:0] clip32(logic signed [95:0] x);
			if (x > 64'sd2147483647)
				return 64'sd2147483647;
			if (x < -64'sd2147483648)
				return -64'sd2147483648;
			return x;
		endfunction

		function logic signed [95:0] coef(pix_word_t val, pix_word_t tag);
			logic signed [95:0] v, t;
			v = $signed(val);
			t = $signed(tag);
			if (t > 0)
				return clip32((v <<< 16) / t);
			return v;
		endfunction

		function pix_word_t predict_next_pix(stencil_t p);
			logic signed [95:0] c, kc, ks, ke, sum, sc, r;
			c = $signed(p.ctr);
			kc = coef(p.kc_val, p.kc_tag);
			ks = coef(p.ks_val, p.ks_tag);
			ke = coef(p.ke_val, p.ke_tag);
			sum = ((kc * ($signed(p.nth) - c)) >>> 16) + ((kc * ($signed(p.wst) - c)) >>> 16)
				+ ((ks * ($signed(p.sth) - c)) >>> 16) + ((ke * ($signed(p.est) - c)) >>> 16);
			sc = {79'd0, scale};
			r = clip32(c + ((sc * sum) >>> 16));
			return r[31:0];
		endfunction

		function void note_pixel(stencil_t p);
			want_next.push_back(predict_next_pix(p));
		endfunction

		function void check_next_pix(pix_word_t got);
			pix_word_t exp_pix;
			seen_cnt++;
			if (want_next.size() == 0) begin
				bad_cnt++;
				if (bad_cnt <= 10)
					$display("next_pix %h arrived with nothing pending", got);
				return;
			end
			exp_pix = want_next.pop_front();
			if (got !== exp_pix) begin
				bad_cnt++;
				if (bad_cnt <= 10)
					$display("next_pix mismatch: expected %h, got %h", exp_pix, got);
			end
		endfunction

		function int pending();
			return want_next.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pix_valid = 1'b0;
	logic pix_stall;
	pix_word_t center_pix = '0;
	pix_word_t north_pix = '0;
	pix_word_t south_pix = '0;
	pix_word_t west_pix = '0;
	pix_word_t east_pix = '0;
	pix_word_t center_coef_val = '0;
	pix_word_t center_coef_tag = '0;
	pix_word_t south_coef_val = '0;
	pix_word_t south_coef_tag = '0;
	pix_word_t east_coef_val = '0;
	pix_word_t east_coef_tag = '0;
	logic next_valid;
	logic next_stall = 1'b0;
	logic [31:0] next_pix;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [SCALE_W-1:0] diff_scale = SCALE_RST;

	next_pix_tracker book = new();

	int cycle_cnt = 0;
	int burst_left = 0;
	int words_in = 0;
	int scales_used = 1;
	bit steady = 1'b0;
	bit hold_req = 1'b0;
	bit hold_taken = 1'b0;
	int hold_left = 0;
	int mode_left = 0;
	stall_mode_t stall_mode = STALL_NONE;
	logic [7:0] stall_pat = '0;

	diffusion_stencil_update uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.pix_valid       (pix_valid),
		.pix_stall       (pix_stall),
		.center_pix      (center_pix),
		.north_pix       (north_pix),
		.south_pix       (south_pix),
		.west_pix        (west_pix),
		.east_pix        (east_pix),
		.center_coef_val (center_coef_val),
		.center_coef_tag (center_coef_tag),
		.south_coef_val  (south_coef_val),
		.south_coef_tag  (south_coef_tag),
		.east_coef_val   (east_coef_val),
		.east_coef_tag   (east_coef_tag),
		.next_valid      (next_valid),
		.next_stall      (next_stall),
		.next_pix        (next_pix),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.diff_scale      (diff_scale)
	);

	always #10 clk = ~clk;

	always @(posedge clk)
		cycle_cnt++;

	always @(posedge clk)
		if (arst_n && next_valid && !next_stall)
			book.check_next_pix(next_pix);

	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left = HOLD_CYC;
		end
		if (hold_left > 0) begin
			hold_left--;
			next_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 96);
				stall_pat = 8'($urandom);
			end
			mode_left--;
			case (stall_mode)
				STALL_NONE: next_stall <= 1'b0;
				STALL_LIGHT: next_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: next_stall <= ($urandom_range(0, 9) < 7);
				default: begin
					next_stall <= stall_pat[0];
					stall_pat = {stall_pat[0], stall_pat[7:1]};
				end
			endcase
		end
	end

	function automatic stencil_t stencil(pix_word_t c, n, s, w, e, kv, kt, sv, st, ev, et);
		stencil_t p;
		p = '{c, n, s, w, e, kv, kt, sv, st, ev, et};
		return p;
	endfunction

	function automatic pix_word_t rand_extreme();
		bit sgn, body;
		sgn = 1'($urandom_range(0, 1));
		body = 1'($urandom_range(0, 1));
		return {sgn, {31{body}}};
	endfunction

	function automatic pix_word_t rand_pix();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return $urandom_range(0, 32'h00FF_FFFF);
			6, 7: return $urandom;
			8: return rand_extreme();
			default: return 32'(-int'($urandom_range(0, 32'h00FF_FFFF)));
		endcase
	endfunction

	function automatic pix_word_t rand_val();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom_range(0, 32'h0002_0000);
			4: return 32'(-int'($urandom_range(0, 32'h0002_0000)));
			5, 6: return $urandom;
			7: return rand_extreme();
			default: return $urandom_range(0, 32'h0000_FFFF);
		endcase
	endfunction

	function automatic pix_word_t rand_tag();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return {1'b1, 31'($urandom)};
			2, 3, 4: return $urandom_range(32'h0000_4000, 32'h0004_0000);
			5: return $urandom_range(1, 16);
			6, 7: return $urandom;
			8: return rand_extreme();
			default: return 32'd1;
		endcase
	endfunction

	function automatic stencil_t rand_stencil();
		return stencil(rand_pix(), rand_pix(), rand_pix(), rand_pix(), rand_pix(),
			rand_val(), rand_tag(), rand_val(), rand_tag(), rand_val(), rand_tag());
	endfunction

	task automatic send_item(stencil_t p);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				pix_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		pix_valid <= 1'b1;
		center_pix <= p.ctr;
		north_pix <= p.nth;
		south_pix <= p.sth;
		west_pix <= p.wst;
		east_pix <= p.est;
		center_coef_val <= p.kc_val;
		center_coef_tag <= p.kc_tag;
		south_coef_val <= p.ks_val;
		south_coef_tag <= p.ks_tag;
		east_coef_val <= p.ke_val;
		east_coef_tag <= p.ke_tag;
		do @(posedge clk); while (pix_stall);
		book.note_pixel(p);
		words_in++;
	endtask

	task automatic drain_results();
		pix_valid <= 1'b0;
		while (book.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic write_scale(logic [SCALE_W-1:0] v);
		cfg_valid <= 1'b1;
		diff_scale <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		book.scale = v;
		scales_used++;
	endtask

	task automatic run_phase(logic [SCALE_W-1:0] scale, int n, bit with_hold);
		drain_results();
		write_scale(scale);
		if (with_hold) begin
			hold_req = 1'b1;
			steady = 1'b1;
		end
		for (int i = 0; i < n; i++) begin
			if (i == 80)
				steady = 1'b0;
			send_item(rand_stencil());
		end
	endtask

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("timeout after %0d cycles", cycle_cnt);
		$display("status: fail");
		$finish;
	end

	initial begin
		stencil_t directed[$];
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed.push_back(stencil('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
		directed.push_back(stencil(PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX,
			PIX_MAX, '0, PIX_MAX, '0, PIX_MAX, '0));
		directed.push_back(stencil(PIX_MIN, PIX_MIN, PIX_MIN, PIX_MIN, PIX_MIN,
			PIX_MIN, '0, PIX_MIN, '0, PIX_MIN, '0));
		directed.push_back(stencil('0, PIX_MAX, PIX_MIN, PIX_MAX, PIX_MIN,
			ONE_Q, '0, ONE_Q, '0, ONE_Q, '0));
		directed.push_back(stencil(32'h0010_0000, 32'h0020_0000, '0, 32'h0030_0000,
			32'hFFF0_0000, ONE_Q, 32'h0002_0000, 32'h0000_8000, 32'hFFFF_FFFB, ONE_Q, PIX_MIN));
		directed.push_back(stencil('0, 32'h0100_0000, 32'hFF00_0000, 32'h0000_1000,
			32'h7000_0000, PIX_MAX, PIX_MAX, PIX_MAX, 32'd1, PIX_MIN, 32'd1));
		directed.push_back(stencil('0, 32'd3, 32'd3, 32'd3, 32'd3,
			32'hFFFF_FFFF, 32'd3, 32'd1, 32'd3, 32'hFFFF_0000, 32'd7));
		directed.push_back(stencil(32'h7F00_0000, PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX,
			PIX_MAX, '0, PIX_MAX, '0, PIX_MAX, '0));
		directed.push_back(stencil(32'h8100_0000, PIX_MIN, PIX_MIN, PIX_MIN, PIX_MIN,
			PIX_MAX, '0, PIX_MAX, '0, PIX_MAX, '0));
		directed.push_back(stencil(PIX_MIN, PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX,
			PIX_MIN, '0, PIX_MIN, '0, PIX_MIN, '0));
		directed.push_back(stencil(PIX_MAX, PIX_MIN, PIX_MIN, PIX_MIN, PIX_MIN,
			PIX_MIN, '0, PIX_MIN, '0, PIX_MIN, '0));
		directed.push_back(stencil('0, 32'd1, '0, '0, '0,
			32'hFFFF_FFFF, '0, '0, '0, '0, '0));
		directed.push_back(stencil(32'd5, 32'd5, 32'd5, 32'd5, 32'd5,
			32'h1234_5678, '0, 32'h0000_4000, 32'd9, PIX_MAX, 32'd1));
		directed.push_back(stencil(32'h0005_0000, '0, 32'h000A_0000, 32'h0001_0000,
			32'h0009_0000, '0, 32'd1, 32'd1, 32'd1, PIX_MIN, PIX_MAX));
		directed.push_back(stencil('1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
		directed.push_back(stencil(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
			32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
			32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'h5555_5555));
		directed.push_back(stencil(32'h0080_0000, 32'h0081_0000, 32'h007F_0000,
			32'h0080_8000, 32'h0080_0001, 32'h0000_C000, 32'h0001_0000,
			32'h0000_2000, PIX_MIN, 32'hFFFF_8000, 32'h0000_0100));
		foreach (directed[i])
			send_item(directed[i]);

		run_phase(17'd65536, 100, 1'b0);
		run_phase(17'd0, 60, 1'b0);
		run_phase(17'd131071, 140, 1'b1);
		run_phase(17'd1, 60, 1'b0);
		run_phase(17'($urandom_range(0, 131071)), 100, 1'b0);
		run_phase(17'd65535, 60, 1'b0);
		run_phase(17'($urandom_range(0, 65536)), 100, 1'b0);
		run_phase(SCALE_RST, 80, 1'b0);
		drain_results();

		$display("%0d pixel words sent, %0d results compared, %0d diff_scale settings",
			words_in, book.seen_cnt, scales_used);
		$display("scale 0, 1, 65536 and 131071 used; long output hold-off done; %0d mismatches",
			book.bad_cnt);
		if (book.bad_cnt == 0 && book.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
